// ===== rtl/tab_separated_cell_parser_macros.svh =====
// Assertion helpers for the cell parser.
`ifndef TAB_SEPARATED_CELL_PARSER_MACROS_SVH
`define TAB_SEPARATED_CELL_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define TSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tsc assertion failed");
// Expression must never be true outside reset.
`define TSC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("tsc forbidden condition");
`else
`define TSC_ASSERT(lbl, prop)
`define TSC_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/tsc_pkg.sv =====
`default_nettype none

package tsc_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_CELL  = 3'b010,
    PH_SKIP  = 3'b100
  } phase_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       cell_end;
    logic       row_end;
  } tsc_res_t;

  // Per-cell parser state.
  typedef struct packed {
    phase_t     phase;
    logic       quoted_cell;
    logic       held_valid;
    logic [7:0] held_byte;
    logic       last_out_was_quote;
    logic       cut_by_zero;
  } tsc_state_t;

endpackage

`default_nettype wire

// ===== rtl/tsc_parse.sv =====
`default_nettype none

module tsc_parse import tsc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,        // request accepted this cycle
  input  wire logic [7:0] in_byte,
  input  wire logic       final_byte,
  output logic            res_valid,
  output tsc_res_t        res,
  output phase_t          phase
);

  tsc_state_t st, st_next;
  logic       is_term;
  logic       content;
  logic       emit_req;
  logic [7:0] emit_val;

  assign phase = st.phase;

  always_comb begin
    st_next   = st;
    res_valid = 1'b0;
    res       = '0;
    is_term   = (in_byte == CH_TAB) || (in_byte == CH_CR);
    content   = 1'b0;
    emit_req  = 1'b0;
    emit_val  = in_byte;

    if (st.phase == PH_SKIP) begin
      st_next.phase = PH_START;
    end else if (is_term) begin
      st_next              = '0;
      st_next.phase        = (in_byte == CH_CR) ? PH_SKIP : PH_START;
      res_valid            = 1'b1;
      res.cell_end         = 1'b1;
      res.row_end          = (in_byte == CH_CR);
    end else if (st.phase == PH_START) begin
      st_next.phase = PH_CELL;
      if (in_byte == CH_QUOTE) begin
        st_next.quoted_cell = 1'b1;
      end else begin
        content = 1'b1;
      end
    end else begin
      content = 1'b1;
    end

    // content byte path; a zero cuts the rest of the cell
    if (content && !st.cut_by_zero) begin
      if (in_byte == CH_NUL) begin
        emit_req            = st.quoted_cell && st.held_valid;
        emit_val            = st.held_byte;
        st_next.held_valid  = 1'b0;
        st_next.held_byte   = '0;
        st_next.cut_by_zero = 1'b1;
      end else if (st.quoted_cell) begin
        emit_req           = st.held_valid;
        emit_val           = st.held_byte;
        st_next.held_byte  = in_byte;
        st_next.held_valid = 1'b1;
      end else begin
        emit_req = 1'b1;
      end
    end

    // quote runs collapse to one quote
    if (emit_req && !(emit_val == CH_QUOTE && st.last_out_was_quote)) begin
      st_next.last_out_was_quote = (emit_val == CH_QUOTE);
      res_valid    = 1'b1;
      res.out_byte = emit_val;
    end

    if (final_byte) begin
      st_next       = '0;
      st_next.phase = PH_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{PH_START, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
    end else if (take) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tsc_out_buf.sv =====
`default_nettype none

module tsc_out_buf import tsc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire tsc_res_t push_res,
  output logic          ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output tsc_res_t      out_res
);

  tsc_res_t main_res, skid_res;
  logic     main_valid, skid_valid;
  logic     pop, load_main, load_skid, main_from_skid;

  assign ready     = !skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  assign pop            = main_valid && out_ready;
  assign main_from_skid = pop && skid_valid;
  assign load_skid      = push && main_valid && !pop;
  assign load_main      = push && !load_skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (main_from_skid) begin
        skid_valid <= 1'b0;
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end
      if (load_main || main_from_skid) begin
        main_valid <= 1'b1;
      end else if (pop) begin
        main_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (main_from_skid) begin
      main_res <= skid_res;
    end else if (load_main) begin
      main_res <= push_res;
    end
    if (load_skid) begin
      skid_res <= push_res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tab_separated_cell_parser.sv =====
// Results are registered in the output buffer before they appear on the master side.
// Throughput: one input byte per cycle, sustained while the master side drains.
// A two-entry output buffer lets input continue while one result waits.
// Reset (rst, synchronous, active high) returns to start of cell, empties buffers.
`default_nettype none

`include "tab_separated_cell_parser_macros.svh"

module tab_separated_cell_parser import tsc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  // slave side: text bytes
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tlast,   // final_byte
  // master side: cell content and end marks
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic [1:0]      m_tuser    // [0] cell_end, [1] row_end
);

  logic     take;
  logic     res_valid;
  tsc_res_t res;
  tsc_res_t out_res;
  phase_t   phase;

  // a request is taken whenever the skid slot is free
  assign take = s_tvalid && s_tready;

  // single-pass byte decision: tab/CR terminators, quote handling,
  // one-byte hold for quoted cells, zero cut, skip after CR
  tsc_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .in_byte    (s_tdata),
    .final_byte (s_tlast),
    .res_valid  (res_valid),
    .res        (res),
    .phase      (phase)
  );

  // result register plus skid slot
  tsc_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_res  (res),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = out_res.out_byte;
  assign m_tuser = {out_res.row_end, out_res.cell_end};

  // end marks carry no byte
  `TSC_ASSERT(a_end_no_byte, (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'h00))
  // a row end is always a cell end
  `TSC_ASSERT_NEVER(a_row_wo_cell, m_tvalid && m_tuser[1] && !m_tuser[0])
  // back-pressure only when the result register is occupied
  `TSC_ASSERT(a_stall_has_out, !s_tready |-> m_tvalid)
  // a final byte leaves the parser at start of cell
  `TSC_ASSERT(a_final_resets, (take && s_tlast) |=> (phase == PH_START))

endmodule

`default_nettype wire
